FILE: hw/rtl/gssp_pkg.sv
package gssp_pkg;

   localparam int E_W = 9;
   localparam int X_W = 8;
   localparam int Q8_W = 17;
   localparam int TOT_W = 34;
   localparam int OPA_W = 32;
   localparam int OPB_W = 18;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int DVS_W = 12;
   localparam int CNT_W = 6;
   localparam int MUL_STEPS = OPB_W;
   localparam int DIV_STEPS = OPA_W;
   localparam int FRAC_BITS = 8;
   localparam int HISTORY_DEPTH_DEF = 5;

   localparam int CUBE_DIV = 2744;
   localparam int KA_CUBE_DIV = 1000;
   localparam int ANGLE_SCALE = 100;
   localparam int KP_OFFSET_Q8 = 30 * 256;
   localparam int KP_MIN_Q8 = 50 * 256;
   localparam int KP_MAX_Q8 = 450 * 256;
   localparam int KA_BASE_Q8 = 250 * 256;
   localparam int KA_MIN_Q8 = 150 * 256;
   localparam int KA_MAX_Q8 = 350 * 256;
   localparam int INT_THRESHOLD = 50;
   localparam int LOST_TICK_LIMIT = 50;
   localparam int LIMIT_LOST_EARLY = 10000;
   localparam int LIMIT_LOST = 9000;
   localparam int LIMIT_NOJUDGE = 8000;

   typedef enum logic [2:0] {
      CSR_GAIN_MODE        = 3'd0,
      CSR_ERROR_LIMIT      = 3'd1,
      CSR_INTEGRAL_LIMIT   = 3'd2,
      CSR_INTEGRAL_GAIN    = 3'd3,
      CSR_NORMAL_OUT_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic             is_div;
      logic [OPA_W-1:0] a;
      logic [OPB_W-1:0] b;
   } unit_op_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
      logic [OPA_W-1:0]  quot;
      logic              rem_nz;
   } unit_res_type;

   typedef struct packed {
      logic [8:0] kp;
      logic [7:0] kd;
      logic [8:0] ka;
   } gain_type;

   function automatic gain_type step_gain(input logic [X_W-1:0] x);
      gain_type g;
      if (x <= X_W'(30)) begin
         g = '{kp: 9'd50, kd: 8'd100, ka: 9'd300};
      end else if (x <= X_W'(50)) begin
         g = '{kp: 9'd100, kd: 8'd100, ka: 9'd250};
      end else if (x <= X_W'(80)) begin
         g = '{kp: 9'd275, kd: 8'd50, ka: 9'd275};
      end else if (x <= X_W'(100)) begin
         g = '{kp: 9'd320, kd: 8'd50, ka: 9'd250};
      end else begin
         g = '{kp: 9'd450, kd: 8'd150, ka: 9'd150};
      end
      return g;
   endfunction

   function automatic logic [TOT_W-1:0] floor_signed(input logic [OPA_W-1:0] q,
                                                     input logic rem_nz, input logic neg);
      logic [TOT_W-1:0] ext;
      ext = TOT_W'(q);
      return neg ? (TOT_W'(0) - ext - TOT_W'(rem_nz)) : ext;
   endfunction

   function automatic logic [TOT_W-1:0] signed_term(input logic [TOT_W-1:0] mag,
                                                    input logic neg);
      return neg ? (TOT_W'(0) - mag) : mag;
   endfunction

endpackage

FILE: hw/rtl/gssp_serial_unit.sv
module gssp_serial_unit import gssp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  unit_op_type  op,
   output unit_res_type res
);

   logic              busy_ff, busy_in;
   logic              is_div_ff, is_div_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OPA_W-1:0]  a_ff, a_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [OPA_W-1:0]  quo_ff, quo_in;
   logic [OPA_W:0]    mul_sum;
   logic [DVS_W:0]    trial;
   logic              ge;

   always_comb begin
      mul_sum = {1'b0, acc_ff[PROD_W-1:OPB_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      trial = {rem_ff, quo_ff[OPA_W-1]};
      ge = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      is_div_in = is_div_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      a_in = a_ff;
      dvs_in = dvs_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (op.start) begin
         busy_in = 1'b1;
         is_div_in = op.is_div;
         cnt_in = op.is_div ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
         a_in = op.a;
         dvs_in = op.b[DVS_W-1:0];
         acc_in = {OPA_W'(0), op.b};
         rem_in = '0;
         quo_in = op.a;
      end else if (busy_ff) begin
         if (is_div_ff) begin
            rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
            quo_in = {quo_ff[OPA_W-2:0], ge};
         end else begin
            acc_in = {mul_sum, acc_ff[OPB_W-1:1]};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      dvs_ff <= dvs_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign res.done = done_ff;
   assign res.prod = acc_ff;
   assign res.quot = quo_ff;
   assign res.rem_nz = |rem_ff;

endmodule

FILE: hw/rtl/gain_scheduled_steering_pid.sv
// Gain-scheduled steering PID with gyro damping. One word in gives one drive word out.
// All products and quotients but the final shift by FRAC_BITS go through one
// shared bit-serial unit: eight multiplies and four divides, one at a time.
// req_stall stays high from acceptance until the result is loaded into the
// output register; the next word may enter while that result still waits.
// The user must write configuration only while idle; the block does not enforce it.
module gain_scheduled_steering_pid import gssp_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [10:0] req_target,
   input  logic signed [15:0] req_position,
   input  logic signed [15:0] req_gyro_rate,
   input  logic               req_line_lost,
   input  logic        [15:0] req_lost_ticks,
   input  logic        [7:0]  req_recovery_count,
   input  logic               req_no_judge,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_drive,
   input  logic               csr_write_enable,
   input  logic        [2:0]  csr_index,
   input  logic        [14:0] csr_write_data
);

   localparam int HSUM_W = E_W + $clog2(HISTORY_DEPTH);
   localparam int DM_W = E_W + FRAC_BITS + 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LAUNCH = 5'b00010,
      ST_WAIT   = 5'b00100,
      ST_SEL    = 5'b01000,
      ST_FIN    = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      SP_KP_SQ, SP_KP_CUBE, SP_KP_DIV, SP_KA_SQ, SP_KA_CUBE, SP_KA_DIV,
      SP_G_MUL, SP_G_DIV, SP_P_MUL, SP_I_MUL, SP_M_DIV, SP_D_MUL
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic        gain_mode_ff, gain_mode_in;
   logic [7:0]  error_limit_ff, error_limit_in;
   logic [9:0]  integral_limit_ff, integral_limit_in;
   logic [9:0]  integral_gain_ff, integral_gain_in;
   logic [14:0] normal_out_limit_ff, normal_out_limit_in;

   logic [E_W-1:0]   e_ff, e_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [15:0]      gyro_ff, gyro_in;
   logic             lost_ff, lost_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic [7:0]       rec_ff, rec_in;
   logic             nj_ff, nj_in;
   logic [OPA_W-1:0] tmp_ff, tmp_in;
   logic [Q8_W-1:0]  kp_cubic_ff, kp_cubic_in;
   logic [Q8_W-1:0]  ka_cubic_ff, ka_cubic_in;
   logic [Q8_W-1:0]  kp_ff, kp_in;
   logic [Q8_W-1:0]  ka_ff, ka_in;
   logic [7:0]       held_kd_ff, held_kd_in;
   logic [14:0]      lim_ff, lim_in;
   logic [10:0]      integ_ff, integ_in;
   logic [E_W-1:0]   hist_ff [HISTORY_DEPTH];
   logic [E_W-1:0]   hist_in [HISTORY_DEPTH];
   logic [HSUM_W-1:0] hsum_ff, hsum_in;
   logic [DM_W-1:0]  mean_ff, mean_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      drive_ff, drive_in;

   unit_op_type  op;
   unit_res_type res;

   logic [16:0]       diff, elim17;
   logic [8:0]        d9, d_neg9;
   logic              d_neg;
   logic [7:0]        d_mag;
   logic [16:0]       g_neg17;
   logic [15:0]       g_mag;
   logic [10:0]       i_neg11;
   logic [9:0]        i_mag;
   logic [HSUM_W-1:0] hs_neg;
   logic [HSUM_W-1:0] hs_mag;
   logic [DM_W-1:0]   dm;
   logic [DM_W-1:0]   dm_neg;
   logic [OPB_W-1:0]  dm_mag;
   logic [TOT_W-1:0]  raw;
   gain_type          tbl;
   logic [Q8_W-1:0]   kp_sel, ka_sel;
   logic [7:0]        kd_sel;
   logic [14:0]       lim_sel;
   logic [11:0]       isum, ilim12;
   logic [TOT_W-1:0]  tq;
   logic [TOT_W-1:0]  lim_t;

   gssp_serial_unit u_unit (
      .clock(clock),
      .reset(reset),
      .op(op),
      .res(res)
   );

   always_comb begin
      diff = {{6{req_target[10]}}, req_target} - {req_position[15], req_position};
      elim17 = {9'd0, error_limit_ff};
      d9 = 9'd50 - {1'b0, x_ff};
      d_neg = d9[8];
      d_neg9 = 9'd0 - d9;
      d_mag = d_neg ? d_neg9[7:0] : d9[7:0];
      g_neg17 = 17'd0 - {gyro_ff[15], gyro_ff};
      g_mag = gyro_ff[15] ? g_neg17[15:0] : gyro_ff;
      i_neg11 = 11'd0 - integ_ff;
      i_mag = integ_ff[10] ? i_neg11[9:0] : integ_ff[9:0];
      hs_neg = HSUM_W'(0) - hsum_ff;
      hs_mag = hsum_ff[HSUM_W-1] ? hs_neg : hsum_ff;
      dm = {{2{e_ff[E_W-1]}}, e_ff, 8'h00} - mean_ff;
      dm_neg = DM_W'(0) - dm;
      dm_mag = dm[DM_W-1] ? OPB_W'(dm_neg) : OPB_W'(dm);
   end

   always_comb begin
      op.start = state_ff == ST_LAUNCH;
      op.is_div = 1'b0;
      op.a = '0;
      op.b = '0;
      unique case (step_ff)
         SP_KP_SQ: begin
            op.a = OPA_W'(x_ff);
            op.b = OPB_W'(x_ff);
         end
         SP_KP_CUBE: begin
            op.a = OPA_W'(tmp_ff[15:0]);
            op.b = OPB_W'(x_ff);
         end
         SP_KP_DIV: begin
            op.is_div = 1'b1;
            op.a = {tmp_ff[23:0], 8'h00};
            op.b = OPB_W'(CUBE_DIV);
         end
         SP_KA_SQ: begin
            op.a = OPA_W'(d_mag);
            op.b = OPB_W'(d_mag);
         end
         SP_KA_CUBE: begin
            op.a = OPA_W'(tmp_ff[15:0]);
            op.b = OPB_W'(d_mag);
         end
         SP_KA_DIV: begin
            op.is_div = 1'b1;
            op.a = {tmp_ff[23:0], 8'h00};
            op.b = OPB_W'(KA_CUBE_DIV);
         end
         SP_G_MUL: begin
            op.a = OPA_W'(ka_ff);
            op.b = OPB_W'(g_mag);
         end
         SP_G_DIV: begin
            op.is_div = 1'b1;
            op.a = tmp_ff;
            op.b = OPB_W'(ANGLE_SCALE);
         end
         SP_P_MUL: begin
            op.a = OPA_W'(kp_ff);
            op.b = OPB_W'(x_ff);
         end
         SP_I_MUL: begin
            op.a = OPA_W'(integral_gain_ff);
            op.b = OPB_W'(i_mag);
         end
         SP_M_DIV: begin
            op.is_div = 1'b1;
            op.a = OPA_W'({hs_mag, 8'h00});
            op.b = OPB_W'(HISTORY_DEPTH);
         end
         SP_D_MUL: begin
            op.a = OPA_W'(held_kd_ff);
            op.b = dm_mag;
         end
         default: begin
            op.a = '0;
         end
      endcase
   end

   always_comb begin
      tbl = step_gain(x_ff);
      if (gain_mode_ff) begin
         kp_sel = {tbl.kp, 8'h00};
         ka_sel = {tbl.ka, 8'h00};
         kd_sel = tbl.kd;
      end else begin
         kp_sel = kp_cubic_ff;
         ka_sel = ka_cubic_ff;
         kd_sel = held_kd_ff;
      end
      priority if (lost_ff && rec_ff == 8'd0) begin
         if (ticks_ff <= 16'(LOST_TICK_LIMIT)) begin
            lim_sel = 15'(LIMIT_LOST_EARLY);
            kp_sel = Q8_W'(500 * 256);
            kd_sel = 8'd200;
            ka_sel = Q8_W'(150 * 256);
         end else begin
            lim_sel = 15'(LIMIT_LOST);
            kp_sel = Q8_W'(400 * 256);
            kd_sel = 8'd100;
            ka_sel = Q8_W'(275 * 256);
         end
      end else if (lost_ff) begin
         lim_sel = 15'(LIMIT_LOST);
         kp_sel = Q8_W'(350 * 256);
         kd_sel = 8'd100;
         ka_sel = Q8_W'(275 * 256);
      end else if (nj_ff) begin
         lim_sel = 15'(LIMIT_NOJUDGE);
         kp_sel = Q8_W'(300 * 256);
         kd_sel = 8'd100;
         ka_sel = Q8_W'(275 * 256);
      end else begin
         lim_sel = normal_out_limit_ff;
      end
      isum = {integ_ff[10], integ_ff} + {{3{e_ff[E_W-1]}}, e_ff};
      ilim12 = {2'b00, integral_limit_ff};
      tq = TOT_W'($signed(total_ff) >>> FRAC_BITS);
      if (total_ff[TOT_W-1] && (total_ff[7:0] != 8'h00)) begin
         tq = tq + 1'b1;
      end
      lim_t = TOT_W'(lim_ff);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      gain_mode_in = gain_mode_ff;
      error_limit_in = error_limit_ff;
      integral_limit_in = integral_limit_ff;
      integral_gain_in = integral_gain_ff;
      normal_out_limit_in = normal_out_limit_ff;
      e_in = e_ff;
      x_in = x_ff;
      gyro_in = gyro_ff;
      lost_in = lost_ff;
      ticks_in = ticks_ff;
      rec_in = rec_ff;
      nj_in = nj_ff;
      tmp_in = tmp_ff;
      kp_cubic_in = kp_cubic_ff;
      ka_cubic_in = ka_cubic_ff;
      kp_in = kp_ff;
      ka_in = ka_ff;
      held_kd_in = held_kd_ff;
      lim_in = lim_ff;
      integ_in = integ_ff;
      hist_in = hist_ff;
      hsum_in = hsum_ff;
      mean_in = mean_ff;
      total_in = total_ff;
      drive_in = drive_ff;
      raw = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_MODE:        gain_mode_in = csr_write_data[0];
            CSR_ERROR_LIMIT:      error_limit_in = csr_write_data[7:0];
            CSR_INTEGRAL_LIMIT:   integral_limit_in = csr_write_data[9:0];
            CSR_INTEGRAL_GAIN:    integral_gain_in = csr_write_data[9:0];
            CSR_NORMAL_OUT_LIMIT: normal_out_limit_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ($signed(diff) > $signed(elim17)) begin
                  e_in = elim17[E_W-1:0];
               end else if ($signed(diff) < -$signed(elim17)) begin
                  e_in = E_W'(17'd0 - elim17);
               end else begin
                  e_in = diff[E_W-1:0];
               end
               x_in = e_in[E_W-1] ? X_W'(E_W'(0) - e_in) : e_in[X_W-1:0];
               gyro_in = req_gyro_rate;
               lost_in = req_line_lost;
               ticks_in = req_lost_ticks;
               rec_in = req_recovery_count;
               nj_in = req_no_judge;
               total_in = '0;
               step_in = SP_KP_SQ;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (res.done) begin
               state_in = ST_LAUNCH;
               step_in = step_type'(step_ff + 1'b1);
               unique case (step_ff)
                  SP_KP_DIV: begin
                     raw = TOT_W'(res.quot) + TOT_W'(KP_OFFSET_Q8);
                     if (raw < TOT_W'(KP_MIN_Q8)) begin
                        kp_cubic_in = Q8_W'(KP_MIN_Q8);
                     end else if (raw > TOT_W'(KP_MAX_Q8)) begin
                        kp_cubic_in = Q8_W'(KP_MAX_Q8);
                     end else begin
                        kp_cubic_in = raw[Q8_W-1:0];
                     end
                  end
                  SP_KA_DIV: begin
                     raw = floor_signed(res.quot, res.rem_nz, d_neg) + TOT_W'(KA_BASE_Q8);
                     if ($signed(raw) < $signed(TOT_W'(KA_MIN_Q8))) begin
                        ka_cubic_in = Q8_W'(KA_MIN_Q8);
                     end else if ($signed(raw) > $signed(TOT_W'(KA_MAX_Q8))) begin
                        ka_cubic_in = Q8_W'(KA_MAX_Q8);
                     end else begin
                        ka_cubic_in = raw[Q8_W-1:0];
                     end
                     state_in = ST_SEL;
                     step_in = step_ff;
                  end
                  SP_G_DIV: begin
                     total_in = total_ff - floor_signed(res.quot, res.rem_nz, gyro_ff[15]);
                  end
                  SP_P_MUL: begin
                     total_in = total_ff + signed_term(TOT_W'(res.prod), e_ff[E_W-1]);
                  end
                  SP_I_MUL: begin
                     total_in = total_ff
                              + signed_term(TOT_W'(res.prod) << FRAC_BITS, integ_ff[10]);
                  end
                  SP_M_DIV: begin
                     mean_in = DM_W'(floor_signed(res.quot, res.rem_nz,
                                                  hsum_ff[HSUM_W-1]));
                  end
                  SP_D_MUL: begin
                     total_in = total_ff + signed_term(TOT_W'(res.prod), dm[DM_W-1]);
                     state_in = ST_FIN;
                     step_in = step_ff;
                  end
                  default: begin
                     tmp_in = res.prod[OPA_W-1:0];
                  end
               endcase
            end
         end
         ST_SEL: begin
            kp_in = kp_sel;
            ka_in = ka_sel;
            held_kd_in = kd_sel;
            lim_in = lim_sel;
            if (x_ff >= X_W'(INT_THRESHOLD)) begin
               if ($signed(isum) > $signed(ilim12)) begin
                  integ_in = ilim12[10:0];
               end else if ($signed(isum) < -$signed(ilim12)) begin
                  integ_in = 11'(12'd0 - ilim12);
               end else begin
                  integ_in = isum[10:0];
               end
            end else begin
               integ_in = '0;
            end
            step_in = SP_G_MUL;
            state_in = ST_LAUNCH;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if ($signed(tq) > $signed(lim_t)) begin
                  drive_in = lim_t[15:0];
               end else if ($signed(tq) < -$signed(lim_t)) begin
                  drive_in = 16'(TOT_W'(0) - lim_t);
               end else begin
                  drive_in = tq[15:0];
               end
               rsp_valid_in = 1'b1;
               hist_in[0] = e_ff;
               for (int i = 1; i < HISTORY_DEPTH; i++) begin
                  hist_in[i] = hist_ff[i-1];
               end
               hsum_in = hsum_ff + HSUM_W'($signed(e_ff))
                       - HSUM_W'($signed(hist_ff[HISTORY_DEPTH-1]));
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= SP_KP_SQ;
         gain_mode_ff <= 1'b0;
         error_limit_ff <= 8'd100;
         integral_limit_ff <= 10'd10;
         integral_gain_ff <= 10'd10;
         normal_out_limit_ff <= 15'd8000;
         held_kd_ff <= '0;
         integ_ff <= '0;
         hsum_ff <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         gain_mode_ff <= gain_mode_in;
         error_limit_ff <= error_limit_in;
         integral_limit_ff <= integral_limit_in;
         integral_gain_ff <= integral_gain_in;
         normal_out_limit_ff <= normal_out_limit_in;
         held_kd_ff <= held_kd_in;
         integ_ff <= integ_in;
         hsum_ff <= hsum_in;
         hist_ff <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff <= e_in;
      x_ff <= x_in;
      gyro_ff <= gyro_in;
      lost_ff <= lost_in;
      ticks_ff <= ticks_in;
      rec_ff <= rec_in;
      nj_ff <= nj_in;
      tmp_ff <= tmp_in;
      kp_cubic_ff <= kp_cubic_in;
      ka_cubic_ff <= ka_cubic_in;
      kp_ff <= kp_in;
      ka_ff <= ka_in;
      lim_ff <= lim_in;
      mean_ff <= mean_in;
      total_ff <= total_in;
      drive_ff <= drive_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      res.done |-> state_ff == ST_WAIT)
      else $error("serial unit finished outside of wait");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result word raised outside of finish");

   a_drive_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> drive_ff != 16'h8000)
      else $error("drive outside symmetric range");

   a_sel_after_ka: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEL |-> step_ff == SP_KA_DIV)
      else $error("gain select reached out of sequence");

endmodule
